>>> hw/rtl/crc16_rfc_pkg.sv
// Shared types, codes and the CRC-16/XMODEM byte update for the reply frame checker.
package crc16_rfc_pkg;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       done_res;
        logic [3:0] status;
    } out_t;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [7:0] expected_command;
        logic [7:0] expected_length;
        logic       check_mode;
    } cfg_t;

    localparam logic [7:0] CFG_SYNC_BYTE        = 8'd0;
    localparam logic [7:0] CFG_EXPECTED_COMMAND = 8'd1;
    localparam logic [7:0] CFG_EXPECTED_LENGTH  = 8'd2;
    localparam logic [7:0] CFG_CHECK_MODE       = 8'd3;

    localparam logic [7:0] RST_SYNC_BYTE        = 8'd0;
    localparam logic [7:0] RST_EXPECTED_COMMAND = 8'd0;
    localparam logic [7:0] RST_EXPECTED_LENGTH  = 8'd8;
    localparam logic       RST_CHECK_MODE       = 1'b0;

    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
    localparam logic [1:0] FUNC_ARM     = 2'd2;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SYNC    = 3'd1;
    localparam logic [2:0] PH_ADDR    = 3'd2;
    localparam logic [2:0] PH_CMD     = 3'd3;
    localparam logic [2:0] PH_LEN     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CRCHI   = 3'd6;
    localparam logic [2:0] PH_CRCLO   = 3'd7;

    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_TO_SYNC       = 4'd1;
    localparam logic [3:0] ST_BAD_SYNC      = 4'd2;
    localparam logic [3:0] ST_TO_ADDR       = 4'd3;
    localparam logic [3:0] ST_BAD_ADDR      = 4'd4;
    localparam logic [3:0] ST_TO_CMD        = 4'd5;
    localparam logic [3:0] ST_BAD_CMD       = 4'd6;
    localparam logic [3:0] ST_TO_LEN        = 4'd7;
    localparam logic [3:0] ST_BAD_LEN       = 4'd8;
    localparam logic [3:0] ST_TO_PAYLOAD    = 4'd9;
    localparam logic [3:0] ST_BAD_PAYLOAD   = 4'd10;
    localparam logic [3:0] ST_TO_CRCHI      = 4'd11;
    localparam logic [3:0] ST_TO_CRCLO      = 4'd12;
    localparam logic [3:0] ST_BAD_CRCHI     = 4'd13;
    localparam logic [3:0] ST_BAD_CRCLO     = 4'd14;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [3:0] timeout_code(input logic [2:0] ph);
        logic [3:0] code;
        case (ph)
            PH_SYNC:    code = ST_TO_SYNC;
            PH_ADDR:    code = ST_TO_ADDR;
            PH_CMD:     code = ST_TO_CMD;
            PH_LEN:     code = ST_TO_LEN;
            PH_PAYLOAD: code = ST_TO_PAYLOAD;
            PH_CRCHI:   code = ST_TO_CRCHI;
            default:    code = ST_TO_CRCLO;
        endcase
        return code;
    endfunction

endpackage

>>> hw/rtl/crc16_rfc_core.sv
// Frame state, running CRC and per-transaction check and result generation.
module crc16_rfc_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  crc16_rfc_pkg::in_t    item,
    input  crc16_rfc_pkg::cfg_t   cfg,
    output logic                  emit,
    output crc16_rfc_pkg::out_t   result
);

    logic [2:0]  phase_reg,         phase_next;
    logic [15:0] crc_reg,           crc_next;
    logic [7:0]  frame_length_reg,  frame_length_next;
    logic [7:0]  byte_count_reg,    byte_count_next;
    logic [7:0]  held_crc_high_reg, held_crc_high_next;

    logic [15:0] crc_fed;
    logic [7:0]  idx;
    logic [7:0]  count_inc;

    assign crc_fed   = crc16_rfc_pkg::crc_feed(crc_reg, item.rx_byte);
    assign count_inc = byte_count_reg + 8'd1;

    always_comb begin
        if (phase_reg == crc16_rfc_pkg::PH_PAYLOAD) begin
            idx = byte_count_reg;
        end else if (phase_reg inside {crc16_rfc_pkg::PH_CRCHI, crc16_rfc_pkg::PH_CRCLO}) begin
            idx = frame_length_reg;
        end else begin
            idx = 8'd0;
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        crc_next           = crc_reg;
        frame_length_next  = frame_length_reg;
        byte_count_next    = byte_count_reg;
        held_crc_high_next = held_crc_high_reg;
        emit               = 1'b0;
        result             = '0;

        if (item.func == crc16_rfc_pkg::FUNC_ARM) begin
            phase_next         = crc16_rfc_pkg::PH_SYNC;
            crc_next           = 16'd0;
            frame_length_next  = 8'd0;
            byte_count_next    = 8'd0;
            held_crc_high_next = 8'd0;
        end else if (phase_reg != crc16_rfc_pkg::PH_IDLE &&
                     item.func == crc16_rfc_pkg::FUNC_TIMEOUT) begin
            emit                 = 1'b1;
            result.done_res      = 1'b1;
            result.payload_index = idx;
            result.status        = crc16_rfc_pkg::timeout_code(phase_reg);
            phase_next           = crc16_rfc_pkg::PH_IDLE;
        end else if (phase_reg != crc16_rfc_pkg::PH_IDLE &&
                     item.func == crc16_rfc_pkg::FUNC_BYTE) begin
            case (phase_reg)
                crc16_rfc_pkg::PH_SYNC: begin
                    if (item.rx_byte != cfg.sync_byte) begin
                        emit            = 1'b1;
                        result.done_res = 1'b1;
                        result.status   = crc16_rfc_pkg::ST_BAD_SYNC;
                        phase_next      = crc16_rfc_pkg::PH_IDLE;
                    end else begin
                        crc_next   = crc_fed;
                        phase_next = crc16_rfc_pkg::PH_ADDR;
                    end
                end
                crc16_rfc_pkg::PH_ADDR: begin
                    if (item.rx_byte != 8'd0) begin
                        emit            = 1'b1;
                        result.done_res = 1'b1;
                        result.status   = crc16_rfc_pkg::ST_BAD_ADDR;
                        phase_next      = crc16_rfc_pkg::PH_IDLE;
                    end else begin
                        crc_next   = crc_fed;
                        phase_next = crc16_rfc_pkg::PH_CMD;
                    end
                end
                crc16_rfc_pkg::PH_CMD: begin
                    if (item.rx_byte != cfg.expected_command) begin
                        emit            = 1'b1;
                        result.done_res = 1'b1;
                        result.status   = crc16_rfc_pkg::ST_BAD_CMD;
                        phase_next      = crc16_rfc_pkg::PH_IDLE;
                    end else begin
                        crc_next   = crc_fed;
                        phase_next = crc16_rfc_pkg::PH_LEN;
                    end
                end
                crc16_rfc_pkg::PH_LEN: begin
                    if (cfg.check_mode ? (item.rx_byte > cfg.expected_length)
                                       : (item.rx_byte != cfg.expected_length)) begin
                        emit            = 1'b1;
                        result.done_res = 1'b1;
                        result.status   = crc16_rfc_pkg::ST_BAD_LEN;
                        phase_next      = crc16_rfc_pkg::PH_IDLE;
                    end else begin
                        crc_next          = crc_fed;
                        frame_length_next = item.rx_byte;
                        byte_count_next   = 8'd0;
                        phase_next        = (item.rx_byte == 8'd0) ? crc16_rfc_pkg::PH_CRCHI
                                                                   : crc16_rfc_pkg::PH_PAYLOAD;
                    end
                end
                crc16_rfc_pkg::PH_PAYLOAD: begin
                    crc_next = crc_fed;
                    if (!cfg.check_mode && item.rx_byte != byte_count_reg) begin
                        emit                 = 1'b1;
                        result.done_res      = 1'b1;
                        result.payload_index = byte_count_reg;
                        result.status        = crc16_rfc_pkg::ST_BAD_PAYLOAD;
                        phase_next           = crc16_rfc_pkg::PH_IDLE;
                    end else begin
                        byte_count_next = count_inc;
                        if (count_inc == frame_length_reg) begin
                            phase_next = crc16_rfc_pkg::PH_CRCHI;
                        end
                        if (cfg.check_mode) begin
                            emit                 = 1'b1;
                            result.payload_valid = 1'b1;
                            result.payload_byte  = item.rx_byte;
                            result.payload_index = byte_count_reg;
                        end
                    end
                end
                crc16_rfc_pkg::PH_CRCHI: begin
                    held_crc_high_next = item.rx_byte;
                    phase_next         = crc16_rfc_pkg::PH_CRCLO;
                end
                default: begin
                    emit                 = 1'b1;
                    result.done_res      = 1'b1;
                    result.payload_index = frame_length_reg;
                    phase_next           = crc16_rfc_pkg::PH_IDLE;
                    if (held_crc_high_reg != crc_reg[15:8]) begin
                        result.status = crc16_rfc_pkg::ST_BAD_CRCHI;
                    end else if (item.rx_byte != crc_reg[7:0]) begin
                        result.status = crc16_rfc_pkg::ST_BAD_CRCLO;
                    end else begin
                        result.status = crc16_rfc_pkg::ST_OK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= crc16_rfc_pkg::PH_IDLE;
            crc_reg           <= 16'd0;
            frame_length_reg  <= 8'd0;
            byte_count_reg    <= 8'd0;
            held_crc_high_reg <= 8'd0;
        end else if (step) begin
            phase_reg         <= phase_next;
            crc_reg           <= crc_next;
            frame_length_reg  <= frame_length_next;
            byte_count_reg    <= byte_count_next;
            held_crc_high_reg <= held_crc_high_next;
        end
    end

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && emit && result.done_res |=> phase_reg == crc16_rfc_pkg::PH_IDLE)
        else $error("frame end did not return to idle");

    a_arm_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.func == crc16_rfc_pkg::FUNC_ARM
        |=> phase_reg == crc16_rfc_pkg::PH_SYNC && crc_reg == 16'd0 && byte_count_reg == 8'd0)
        else $error("arm did not restart the frame");

    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == crc16_rfc_pkg::PH_IDLE |-> !emit)
        else $error("result produced while not armed");

    a_payload_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == crc16_rfc_pkg::PH_PAYLOAD |-> byte_count_reg < frame_length_reg)
        else $error("payload count ran past the frame length");

endmodule

>>> hw/rtl/crc16_response_frame_checker.sv
// Top level: configuration registers, input register, frame checker core and result register.
// Checks a slave reply frame (sync, address 0, command, length, payload, CRC-16/XMODEM
// high and low) one transaction at a time, where each transaction is a received byte, a
// receive timeout or an arm command. A transaction is accepted every cycle while the
// result side takes results. A transaction is captured in the input register at the edge
// that accepts it. Its result is loaded into the result register when the core advances
// it, which waits while an earlier result is held and not taken. The whole byte check
// and CRC update are combinational, between the input register and the result register.
// Transactions that close no frame and pass out no payload byte give no result.
// Configuration writes are always accepted and take effect for bytes processed afterward;
// write them only while no transaction is in flight.
module crc16_response_frame_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  crc16_rfc_pkg::in_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output crc16_rfc_pkg::out_t   m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_index,
    input  logic [7:0]            cfg_data
);

    crc16_rfc_pkg::cfg_t cfg_reg;
    logic                in_valid_reg;
    crc16_rfc_pkg::in_t  in_data_reg;
    logic                out_valid_reg;
    crc16_rfc_pkg::out_t out_data_reg;

    logic                advance;
    logic                emit;
    crc16_rfc_pkg::out_t result;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_byte        <= crc16_rfc_pkg::RST_SYNC_BYTE;
            cfg_reg.expected_command <= crc16_rfc_pkg::RST_EXPECTED_COMMAND;
            cfg_reg.expected_length  <= crc16_rfc_pkg::RST_EXPECTED_LENGTH;
            cfg_reg.check_mode       <= crc16_rfc_pkg::RST_CHECK_MODE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                crc16_rfc_pkg::CFG_SYNC_BYTE:        cfg_reg.sync_byte        <= cfg_data;
                crc16_rfc_pkg::CFG_EXPECTED_COMMAND: cfg_reg.expected_command <= cfg_data;
                crc16_rfc_pkg::CFG_EXPECTED_LENGTH:  cfg_reg.expected_length  <= cfg_data;
                crc16_rfc_pkg::CFG_CHECK_MODE:       cfg_reg.check_mode       <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    crc16_rfc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .emit    (emit),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_data_reg <= result;
        end
    end

endmodule

>>> verif/crc16_response_frame_checker_tb.sv
// Testbench for the reply frame checker: directed frames, then random frames checked against a predictor.
`timescale 1ns / 100ps

module crc16_response_frame_checker_tb;
    import crc16_rfc_pkg::*;

    localparam logic [1:0]  FUNC_SPARE    = 2'd3;
    localparam logic [15:0] GEN_POLY      = 16'h1021;
    localparam int          DRAIN_CYCLES  = 4;
    localparam int          RANDOM_ITEMS  = 1450;
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    typedef enum int {FAULT_NONE, FAULT_FLIP, FAULT_TIMEOUT, FAULT_REARM, FAULT_NOISE} fault_e;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_t        s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_t       m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    // predictor state and register copies
    logic [7:0]  reg_sync = RST_SYNC_BYTE;
    logic [7:0]  reg_cmd = RST_EXPECTED_COMMAND;
    logic [7:0]  reg_len = RST_EXPECTED_LENGTH;
    logic        reg_mode = RST_CHECK_MODE;
    logic [2:0]  frm_phase = PH_IDLE;
    logic [15:0] frm_crc = '0;
    logic [7:0]  frm_len = '0;
    logic [7:0]  frm_count = '0;
    logic [7:0]  frm_crc_hi = '0;

    out_t        expected_results[$];
    out_t        result_want;
    int unsigned mismatches = 0;
    int unsigned live_items = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;

    crc16_response_frame_checker uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] crc,
                                                      input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        repeat (8) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ GEN_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic void close_frame(input logic [7:0] idx, input logic [3:0] st);
        out_t r;
        r = '0;
        r.payload_index = idx;
        r.done_res = 1'b1;
        r.status = st;
        frm_phase = PH_IDLE;
        expected_results.push_back(r);
    endfunction

    // returns 1 when the transaction was not ignored
    function automatic bit predict_frame_check(input in_t item);
        out_t       r;
        logic [7:0] b;
        logic [7:0] idx;
        logic [3:0] st;
        b = item.rx_byte;
        if (item.func == FUNC_ARM) begin
            frm_phase = PH_SYNC;
            frm_crc = '0;
            frm_len = '0;
            frm_count = '0;
            frm_crc_hi = '0;
            return 1'b1;
        end
        if (item.func == FUNC_SPARE || frm_phase == PH_IDLE) begin
            return 1'b0;
        end
        idx = (frm_phase == PH_PAYLOAD) ? frm_count : (frm_phase >= PH_CRCHI) ? frm_len : 8'd0;
        if (item.func == FUNC_TIMEOUT) begin
            case (frm_phase)
                PH_SYNC:    st = ST_TO_SYNC;
                PH_ADDR:    st = ST_TO_ADDR;
                PH_CMD:     st = ST_TO_CMD;
                PH_LEN:     st = ST_TO_LEN;
                PH_PAYLOAD: st = ST_TO_PAYLOAD;
                PH_CRCHI:   st = ST_TO_CRCHI;
                default:    st = ST_TO_CRCLO;
            endcase
            close_frame(idx, st);
            return 1'b1;
        end
        case (frm_phase)
            PH_SYNC: begin
                if (b != reg_sync) begin
                    close_frame(8'd0, ST_BAD_SYNC);
                end else begin
                    frm_crc = crc16_xmodem_byte(frm_crc, b);
                    frm_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (b != 8'h00) begin
                    close_frame(8'd0, ST_BAD_ADDR);
                end else begin
                    frm_crc = crc16_xmodem_byte(frm_crc, b);
                    frm_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (b != reg_cmd) begin
                    close_frame(8'd0, ST_BAD_CMD);
                end else begin
                    frm_crc = crc16_xmodem_byte(frm_crc, b);
                    frm_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (reg_mode ? (b > reg_len) : (b != reg_len)) begin
                    close_frame(8'd0, ST_BAD_LEN);
                end else begin
                    frm_crc = crc16_xmodem_byte(frm_crc, b);
                    frm_len = b;
                    frm_count = '0;
                    frm_phase = (b == 8'd0) ? PH_CRCHI : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                frm_crc = crc16_xmodem_byte(frm_crc, b);
                if (!reg_mode && b != frm_count) begin
                    close_frame(frm_count, ST_BAD_PAYLOAD);
                end else begin
                    if (reg_mode) begin
                        r = '0;
                        r.payload_valid = 1'b1;
                        r.payload_byte = b;
                        r.payload_index = frm_count;
                        expected_results.push_back(r);
                    end
                    frm_count = frm_count + 8'd1;
                    if (frm_count == frm_len) begin
                        frm_phase = PH_CRCHI;
                    end
                end
            end
            PH_CRCHI: begin
                frm_crc_hi = b;
                frm_phase = PH_CRCLO;
            end
            default: begin
                if (frm_crc_hi != frm_crc[15:8]) begin
                    close_frame(frm_len, ST_BAD_CRCHI);
                end else if (b != frm_crc[7:0]) begin
                    close_frame(frm_len, ST_BAD_CRCLO);
                end else begin
                    close_frame(frm_len, ST_OK);
                end
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with none pending: %p", m_data);
                mismatches++;
            end else begin
                result_want = expected_results.pop_front();
                check_field("payload_valid", result_want.payload_valid, m_data.payload_valid);
                check_field("payload_byte", result_want.payload_byte, m_data.payload_byte);
                check_field("payload_index", result_want.payload_index, m_data.payload_index);
                check_field("done_res", result_want.done_res, m_data.done_res);
                check_field("status", result_want.status, m_data.status);
            end
        end
    end

    // result side: when idle_on is set, hold m_ready low for a random stall before each result
    initial begin
        int stall;
        forever begin
            stall = idle_on ? $urandom_range(0, 9) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_item(input logic [1:0] func, input logic [7:0] b);
        in_t item;
        int  gap;
        item.func = func;
        item.rx_byte = b;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        if (predict_frame_check(item)) begin
            live_items++;
        end
    endtask

    // hold off until nothing is in flight
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            CFG_SYNC_BYTE:        reg_sync = value;
            CFG_EXPECTED_COMMAND: reg_cmd = value;
            CFG_EXPECTED_LENGTH:  reg_len = value;
            CFG_CHECK_MODE:       reg_mode = value[0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [7:0] sync, input logic [7:0] cmd,
                                input logic [7:0] len, input logic mode);
        write_reg(CFG_SYNC_BYTE, sync);
        write_reg(CFG_EXPECTED_COMMAND, cmd);
        write_reg(CFG_EXPECTED_LENGTH, len);
        write_reg(CFG_CHECK_MODE, {7'd0, mode});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input int len, input fault_e fault, input int fault_pos);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        frame.push_back(reg_sync);
        frame.push_back(8'h00);
        frame.push_back(reg_cmd);
        frame.push_back(8'(len));
        for (int i = 0; i < len; i++) begin
            frame.push_back(reg_mode ? 8'($urandom) : 8'(i));
        end
        crc = '0;
        foreach (frame[i]) begin
            crc = crc16_xmodem_byte(crc, frame[i]);
        end
        frame.push_back(crc[15:8]);
        frame.push_back(crc[7:0]);
        send_item(FUNC_ARM, 8'($urandom));
        foreach (frame[i]) begin
            if (i == fault_pos) begin
                case (fault)
                    FAULT_FLIP:    frame[i] = frame[i] ^ 8'($urandom_range(1, 255));
                    FAULT_TIMEOUT: send_item(FUNC_TIMEOUT, 8'($urandom));
                    FAULT_REARM:   send_item(FUNC_ARM, 8'($urandom));
                    FAULT_NOISE: begin
                        repeat ($urandom_range(1, 3)) begin
                            send_item(2'($urandom_range(0, 3)), 8'($urandom));
                        end
                    end
                    default: ;
                endcase
            end
            if (frm_phase == PH_IDLE) begin
                break;
            end
            send_item(FUNC_BYTE, frame[i]);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        int pick;
        pick = $urandom_range(0, 9);
        return (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
    endfunction

    task automatic test_unarmed();
        send_item(FUNC_BYTE, 8'h00);
        send_item(FUNC_TIMEOUT, 8'hFF);
        send_item(FUNC_SPARE, 8'hA5);
    endtask

    task automatic test_zero_length();
        wait_idle();
        write_config(8'hFF, 8'hFF, 8'h00, 1'b0);
        send_frame(0, FAULT_NONE, -1);
    endtask

    task automatic test_mode_change_mid_frame();
        logic [7:0]  frame[$];
        logic [15:0] crc;
        wait_idle();
        write_config(8'h5A, 8'h03, 8'hFF, 1'b1);
        frame.push_back(8'h5A);
        frame.push_back(8'h00);
        frame.push_back(8'h03);
        frame.push_back(8'h02);
        frame.push_back(8'hFF);
        frame.push_back(8'h01);
        crc = '0;
        send_item(FUNC_ARM, 8'h00);
        foreach (frame[i]) begin
            if (i == 5) begin
                wait_idle();
                write_config(8'h5A, 8'h03, 8'h00, 1'b0);
            end
            crc = crc16_xmodem_byte(crc, frame[i]);
            send_item(FUNC_BYTE, frame[i]);
        end
        send_item(FUNC_BYTE, crc[15:8]);
        send_item(FUNC_BYTE, crc[7:0]);
    endtask

    task automatic test_rearm();
        send_item(FUNC_ARM, 8'hFF);
        send_item(FUNC_BYTE, reg_sync);
        send_item(FUNC_SPARE, 8'h00);
        send_item(FUNC_ARM, 8'h00);
        send_item(FUNC_TIMEOUT, 8'h00);
    endtask

    task automatic test_random_frames();
        int unsigned target;
        int          pick;
        int          len;
        int          n_frames;
        fault_e      fault;
        target = live_items + RANDOM_ITEMS;
        while (live_items < target) begin
            wait_idle();
            idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 29);
            write_config(pick_byte(), pick_byte(),
                         (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
                         (pick == 2) ? 8'($urandom_range(13, 254)) : 8'($urandom_range(1, 12)),
                         1'($urandom_range(0, 1)));
            n_frames = (!reg_mode && reg_len > 12) ? 2 : $urandom_range(8, 20);
            repeat (n_frames) begin
                pick = $urandom_range(0, 19);
                if (!reg_mode) begin
                    len = reg_len;
                end else if (pick == 0 && reg_len != 8'hFF) begin
                    len = reg_len + 1;
                end else if (pick == 1) begin
                    len = reg_len;
                end else begin
                    len = $urandom_range(0, (reg_len < 12) ? reg_len : 12);
                end
                pick = $urandom_range(0, 99);
                fault = (pick < 65) ? FAULT_NONE : (pick < 80) ? FAULT_FLIP :
                        (pick < 88) ? FAULT_TIMEOUT : (pick < 93) ? FAULT_REARM : FAULT_NOISE;
                send_frame(len, fault, $urandom_range(0, len + 5));
            end
        end
    endtask

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("crc16_response_frame_checker: mismatch");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_unarmed();
        test_zero_length();
        test_mode_change_mid_frame();
        test_rearm();
        test_random_frames();
        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("crc16_response_frame_checker: match");
        end else begin
            $display("crc16_response_frame_checker: mismatch");
        end
        $finish;
    end

endmodule
